>>> hw/rtl/serial_frame_deframer_unit_assert.svh
// Assertion macros shared by the serial frame deframer RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef SERIAL_FRAME_DEFRAMER_UNIT_ASSERT_SVH
`define SERIAL_FRAME_DEFRAMER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define SFD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sfd assertion failed");

// Next-cycle implication, disabled while reset is low.
`define SFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sfd assertion failed");

`endif

>>> hw/rtl/sfd_pkg.sv
// Package of the serial frame deframer: widths, codes, reset values and types.
// Depends on nothing; used by every other file of the block but the assertion header.
package sfd_pkg;

    localparam int BYTE_W          = 8;
    localparam int PAYLOAD_W       = 64;
    localparam int KIND_W          = 2;
    localparam int CFG_IDX_W       = 1;
    localparam int CFG_DATA_W      = 8;
    localparam int MAX_PAYLOAD_DEF = 8;

    localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'h00;
    localparam logic [BYTE_W-1:0] POWER_ID_RST     = 8'h03;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_MARKER = 1'd0,
        CFG_POWER_ID     = 1'd1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        PH_HUNT1 = 3'd0,
        PH_HUNT2 = 3'd1,
        PH_ID    = 3'd2,
        PH_LEN   = 3'd3,
        PH_DATA  = 3'd4
    } t_phase;

    typedef enum logic [KIND_W-1:0] {
        KIND_FORWARD = 2'd0,
        KIND_POWER   = 2'd1,
        KIND_DROPPED = 2'd2
    } t_kind;

    typedef struct packed {
        logic                  we;
        t_cfg_idx              idx;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    typedef struct packed {
        t_kind                kind;
        logic [BYTE_W-1:0]    id;
        logic [BYTE_W-1:0]    length;
        logic [PAYLOAD_W-1:0] payload;
        logic [BYTE_W-1:0]    switches;
    } t_frame;

endpackage

>>> hw/rtl/sfd_byte_if.sv
// Channel interface carrying received serial bytes into the deframer.
// Depends on sfd_pkg for the byte width.
interface sfd_byte_if;
    logic                       valid;
    logic                       ready;
    logic [sfd_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

>>> hw/rtl/sfd_frame_if.sv
// Channel interface carrying completed frame reports out of the deframer.
// Depends on sfd_pkg for field widths.
interface sfd_frame_if;
    logic                          valid;
    logic                          ready;
    logic [sfd_pkg::KIND_W-1:0]    frame_kind;
    logic [sfd_pkg::BYTE_W-1:0]    frame_id;
    logic [sfd_pkg::BYTE_W-1:0]    frame_length;
    logic [sfd_pkg::PAYLOAD_W-1:0] frame_payload;
    logic [sfd_pkg::BYTE_W-1:0]    power_switches;

    modport source (output valid, output frame_kind, output frame_id, output frame_length,
                    output frame_payload, output power_switches, input ready);
    modport sink (input valid, input frame_kind, input frame_id, input frame_length,
                  input frame_payload, input power_switches, output ready);
endinterface

>>> hw/rtl/sfd_in_stage.sv
// Input register of the deframer: holds one accepted byte until the parser takes it.
// Depends on sfd_pkg.
module sfd_in_stage (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [sfd_pkg::BYTE_W-1:0] i_byte,
    input  logic                       i_take,
    output logic                       o_ready,
    output logic                       o_valid,
    output logic [sfd_pkg::BYTE_W-1:0] o_byte
);

    logic                       r_valid;
    logic [sfd_pkg::BYTE_W-1:0] r_byte;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_byte  = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_byte;
        end
    end

endmodule

>>> hw/rtl/sfd_parser.sv
// Frame parser: configuration registers, parse state machine and payload store.
// Depends on sfd_pkg and serial_frame_deframer_unit_assert.svh.
`include "serial_frame_deframer_unit_assert.svh"

module sfd_parser #(
    parameter int MAX_PAYLOAD = sfd_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  sfd_pkg::t_cfg_wr           i_cfg,
    input  logic                       i_go,
    input  logic [sfd_pkg::BYTE_W-1:0] i_byte,
    output logic                       o_res_valid,
    output sfd_pkg::t_frame            o_res
);

    localparam int LP_STORE_W   = MAX_PAYLOAD * sfd_pkg::BYTE_W;
    localparam int LP_PAYLOAD_W = sfd_pkg::PAYLOAD_W;
    localparam logic [sfd_pkg::BYTE_W-1:0] LP_MAX = sfd_pkg::BYTE_W'(MAX_PAYLOAD);

    sfd_pkg::t_phase             r_phase, n_phase;
    logic [sfd_pkg::BYTE_W-1:0]  r_id, n_id;
    logic [sfd_pkg::BYTE_W-1:0]  r_len, n_len;
    logic [sfd_pkg::BYTE_W-1:0]  r_count, n_count;
    logic [LP_STORE_W-1:0]       r_store, n_store;
    logic [sfd_pkg::BYTE_W-1:0]  r_switch, n_switch;
    logic [sfd_pkg::BYTE_W-1:0]  r_start_marker;
    logic [sfd_pkg::BYTE_W-1:0]  r_power_id;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_marker <= sfd_pkg::START_MARKER_RST;
            r_power_id     <= sfd_pkg::POWER_ID_RST;
        end else if (i_cfg.we) begin
            unique case (i_cfg.idx)
                sfd_pkg::CFG_START_MARKER: r_start_marker <= i_cfg.data;
                sfd_pkg::CFG_POWER_ID:     r_power_id     <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= sfd_pkg::PH_HUNT1;
            r_id     <= '0;
            r_len    <= '0;
            r_count  <= '0;
            r_store  <= '0;
            r_switch <= '0;
        end else if (i_go) begin
            r_phase  <= n_phase;
            r_id     <= n_id;
            r_len    <= n_len;
            r_count  <= n_count;
            r_store  <= n_store;
            r_switch <= n_switch;
        end
    end

    logic                       finish;
    logic [sfd_pkg::BYTE_W-1:0] fin_len;
    logic [LP_STORE_W-1:0]      fin_store;
    logic                       oversize;

    always_comb begin
        n_phase     = r_phase;
        n_id        = r_id;
        n_len       = r_len;
        n_count     = r_count;
        n_store     = r_store;
        n_switch    = r_switch;
        finish      = 1'b0;
        fin_len     = r_len;
        fin_store   = r_store;
        oversize    = 1'b0;
        o_res_valid = 1'b0;
        o_res       = '0;

        unique case (r_phase)
            sfd_pkg::PH_HUNT1: begin
                if (i_byte == r_start_marker) begin
                    n_phase = sfd_pkg::PH_HUNT2;
                end
            end
            sfd_pkg::PH_HUNT2: begin
                n_phase = (i_byte == r_start_marker) ? sfd_pkg::PH_ID : sfd_pkg::PH_HUNT1;
            end
            sfd_pkg::PH_ID: begin
                n_id    = i_byte;
                n_phase = sfd_pkg::PH_LEN;
            end
            sfd_pkg::PH_LEN: begin
                n_len     = i_byte;
                n_count   = '0;
                n_store   = '0;
                fin_len   = i_byte;
                fin_store = '0;
                if (i_byte == '0) begin
                    finish = 1'b1;
                end else begin
                    n_phase = sfd_pkg::PH_DATA;
                end
            end
            sfd_pkg::PH_DATA: begin
                if (r_len <= LP_MAX && r_count < LP_MAX) begin
                    for (int k = 0; k < MAX_PAYLOAD; k++) begin
                        if (r_count == sfd_pkg::BYTE_W'(k)) begin
                            fin_store[k*sfd_pkg::BYTE_W +: sfd_pkg::BYTE_W] = i_byte;
                        end
                    end
                end
                n_store = fin_store;
                n_count = r_count + 8'd1;
                if (n_count >= r_len) begin
                    finish = 1'b1;
                end
            end
            default: begin
                n_phase = sfd_pkg::PH_HUNT1;
            end
        endcase

        if (finish) begin
            oversize    = fin_len > LP_MAX;
            o_res_valid = 1'b1;
            o_res.id    = n_id;
            o_res.length = fin_len;
            if (oversize) begin
                o_res.kind    = sfd_pkg::KIND_DROPPED;
                o_res.payload = '0;
            end else begin
                o_res.payload = LP_PAYLOAD_W'(fin_store);
                if (n_id == r_power_id) begin
                    o_res.kind = sfd_pkg::KIND_POWER;
                    if (fin_len != '0) begin
                        n_switch = fin_store[sfd_pkg::BYTE_W-1:0];
                    end
                end else begin
                    o_res.kind = sfd_pkg::KIND_FORWARD;
                end
            end
            o_res.switches = n_switch;
            n_phase        = sfd_pkg::PH_HUNT1;
            n_count        = '0;
            n_store        = '0;
        end
    end

    `SFD_ASSERT_NOW(a_res_only_on_frame_end, i_clk, i_rst_n, o_res_valid && i_go, (r_phase == sfd_pkg::PH_LEN || r_phase == sfd_pkg::PH_DATA))
    `SFD_ASSERT_NEXT(a_hunt_after_frame, i_clk, i_rst_n, i_go && o_res_valid, r_phase == sfd_pkg::PH_HUNT1 && r_count == '0)
    `SFD_ASSERT_NEXT(a_drop_keeps_switches, i_clk, i_rst_n, i_go && o_res_valid && o_res.kind == sfd_pkg::KIND_DROPPED, r_switch == $past(r_switch))
    `SFD_ASSERT_NEXT(a_count_steps, i_clk, i_rst_n, i_go && r_phase == sfd_pkg::PH_DATA && !o_res_valid, r_count == 8'($past(r_count) + 8'd1))

endmodule

>>> hw/rtl/serial_frame_deframer_unit.sv
// Serial frame deframer top level: one received byte per request in, frame reports out.
// A byte's result, if any, is registered at the output. Throughput is one byte per cycle
// while the output is not stalled; a stalled output holds the input back in the same cycle
// once the input register is full. The synchronous active-low reset returns the parser to
// hunting, clears the switch register and loads start marker 0x00 and power frame id 0x03.
// Depends on sfd_pkg, sfd_byte_if, sfd_frame_if, sfd_in_stage and sfd_parser.
module serial_frame_deframer_unit #(
    parameter int MAX_PAYLOAD = sfd_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [sfd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sfd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    sfd_byte_if.sink                       i_rx,
    sfd_frame_if.source                    o_frame
);

    logic                       in_valid;
    logic [sfd_pkg::BYTE_W-1:0] in_byte;
    logic                       go;
    logic                       res_valid;
    sfd_pkg::t_frame            res;
    sfd_pkg::t_cfg_wr           cfg;
    logic                       r_out_valid;
    sfd_pkg::t_frame            r_out;

    assign cfg.we   = i_cfg_we;
    assign cfg.idx  = sfd_pkg::t_cfg_idx'(i_cfg_idx);
    assign cfg.data = i_cfg_data;

    assign go = in_valid && (!r_out_valid || o_frame.ready);

    sfd_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_rx.valid),
        .i_byte  (i_rx.rx_byte),
        .i_take  (go),
        .o_ready (i_rx.ready),
        .o_valid (in_valid),
        .o_byte  (in_byte)
    );

    sfd_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_go        (go),
        .i_byte      (in_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (go) begin
            r_out_valid <= res_valid;
        end else if (o_frame.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go && res_valid) begin
            r_out <= res;
        end
    end

    assign o_frame.valid          = r_out_valid;
    assign o_frame.frame_kind     = r_out.kind;
    assign o_frame.frame_id       = r_out.id;
    assign o_frame.frame_length   = r_out.length;
    assign o_frame.frame_payload  = r_out.payload;
    assign o_frame.power_switches = r_out.switches;

endmodule

>>> tb/serial_frame_deframer_unit_tb.sv
// Self-checking testbench for serial_frame_deframer_unit: directed frames, then random traffic.
// Predicts every frame report from its own parser copy; needs sfd_pkg, sfd_byte_if, sfd_frame_if
// and the deframer RTL.
module serial_frame_deframer_unit_tb;
    import sfd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 8;
    localparam int SETTLE_WAIT  = 4;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int STALL_PCT    = 35;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    sfd_byte_if  rx_if ();
    sfd_frame_if frame_if ();

    serial_frame_deframer_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_rx       (rx_if),
        .o_frame    (frame_if)
    );

    t_frame           pending_frames[$];
    int               err_count   = 0;
    int               bytes_sent  = 0;
    int               cycle_count = 0;
    bit               throttle_en = 1'b1;

    logic [7:0]       cur_marker;
    logic [7:0]       cur_power_id;
    t_phase           parse_ph;
    logic [7:0]       cur_id;
    logic [7:0]       cur_len;
    logic [7:0]       data_count;
    logic [63:0]      data_acc;
    logic [7:0]       switches_now;

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic close_frame();
        t_frame f;
        f.id      = cur_id;
        f.length  = cur_len;
        f.payload = data_acc;
        if (cur_len > MAX_PAYLOAD_DEF) begin
            f.kind    = KIND_DROPPED;
            f.payload = '0;
        end else if (cur_id == cur_power_id) begin
            f.kind = KIND_POWER;
            if (cur_len != 8'd0) switches_now = data_acc[7:0];
        end else begin
            f.kind = KIND_FORWARD;
        end
        f.switches = switches_now;
        pending_frames.push_back(f);
        parse_ph   = PH_HUNT1;
        data_count = '0;
        data_acc   = '0;
    endtask

    task automatic track_byte(input logic [7:0] b);
        case (parse_ph)
            PH_HUNT1: begin
                if (b == cur_marker) parse_ph = PH_HUNT2;
            end
            PH_HUNT2: begin
                parse_ph = (b == cur_marker) ? PH_ID : PH_HUNT1;
            end
            PH_ID: begin
                cur_id   = b;
                parse_ph = PH_LEN;
            end
            PH_LEN: begin
                cur_len    = b;
                data_count = '0;
                data_acc   = '0;
                if (b == 8'd0) close_frame();
                else parse_ph = PH_DATA;
            end
            PH_DATA: begin
                if (cur_len <= MAX_PAYLOAD_DEF && data_count < MAX_PAYLOAD_DEF)
                    data_acc[data_count*8 +: 8] = b;
                data_count = data_count + 8'd1;
                if (data_count >= cur_len) close_frame();
            end
            default: begin
                parse_ph = PH_HUNT1;
            end
        endcase
    endtask

    task automatic send_byte(input logic [7:0] value);
        while (throttle_en && $urandom_range(99) < STALL_PCT) begin
            rx_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= value;
        do @(posedge i_clk); while (rx_if.ready !== 1'b1);
        bytes_sent++;
        track_byte(value);
    endtask

    // Every outstanding request has reported and the pipeline holds no byte.
    task automatic settle();
        rx_if.valid <= 1'b0;
        while (pending_frames.size() != 0) @(posedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);
    endtask

    task automatic apply_config(input logic [7:0] marker, input logic [7:0] power_id);
        settle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_START_MARKER;
        i_cfg_data <= marker;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_POWER_ID;
        i_cfg_data <= power_id;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cur_marker   = marker;
        cur_power_id = power_id;
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            err_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    initial begin : frame_monitor
        t_frame want;
        frame_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && frame_if.valid === 1'b1 && frame_if.ready === 1'b1) begin
                if (pending_frames.size() == 0) begin
                    err_count++;
                    $display("%0t: unexpected frame report, expected none, actual id %h len %h",
                             $time, frame_if.frame_id, frame_if.frame_length);
                end else begin
                    want = pending_frames.pop_front();
                    check_field("frame_kind", 64'(want.kind), 64'(frame_if.frame_kind));
                    check_field("frame_id", 64'(want.id), 64'(frame_if.frame_id));
                    check_field("frame_length", 64'(want.length), 64'(frame_if.frame_length));
                    check_field("frame_payload", want.payload, frame_if.frame_payload);
                    check_field("power_switches", 64'(want.switches),
                                64'(frame_if.power_switches));
                end
            end
            frame_if.ready <= !throttle_en || ($urandom_range(99) >= STALL_PCT);
        end
    end

    task automatic send_random_frame();
        int unsigned roll;
        int unsigned n_data;
        logic [7:0]  fid;
        logic [7:0]  flen;
        logic [7:0]  b;
        if ($urandom_range(99) < 15) begin
            repeat ($urandom_range(1, 3)) begin
                b = 8'($urandom_range(255));
                if (b == cur_marker) b = ~b;
                send_byte(b);
            end
        end
        if ($urandom_range(99) < 8) begin
            b = 8'($urandom_range(255));
            if (b == cur_marker) b = ~b;
            send_byte(cur_marker);
            send_byte(b);
        end else begin
            roll = $urandom_range(99);
            if (roll < 30) fid = cur_power_id;
            else if (roll < 38) fid = cur_marker;
            else fid = 8'($urandom_range(255));
            roll = $urandom_range(99);
            if (roll < 10) flen = 8'd0;
            else if (roll < 75) flen = 8'($urandom_range(1, MAX_PAYLOAD_DEF));
            else if (roll < 97) flen = 8'($urandom_range(MAX_PAYLOAD_DEF + 1, 16));
            else flen = 8'($urandom_range(17, 255));
            n_data = 32'(flen);
            // A cut-short frame lets the next start bytes land in the payload.
            if (flen > 8'd1 && $urandom_range(99) < 5) n_data = $urandom_range(1, flen - 1);
            send_byte(cur_marker);
            send_byte(cur_marker);
            send_byte(fid);
            send_byte(flen);
            repeat (n_data) begin
                roll = $urandom_range(99);
                if (roll < 10) b = 8'h00;
                else if (roll < 20) b = 8'hFF;
                else b = 8'($urandom_range(255));
                send_byte(b);
            end
        end
    endtask

    task automatic run_random_phase(input int n_bytes);
        int start_count;
        start_count = bytes_sent;
        while (bytes_sent - start_count < n_bytes) send_random_frame();
    endtask

    task automatic test_broken_pair_and_triple_start();
        send_byte(8'h00);
        send_byte(8'h5A);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h00);
    endtask

    task automatic test_power_frames();
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(POWER_ID_RST);
        send_byte(8'h01);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(POWER_ID_RST);
        send_byte(8'h00);
    endtask

    task automatic test_oversize_frame();
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(POWER_ID_RST);
        send_byte(8'(MAX_PAYLOAD_DEF + 1));
        for (int k = 1; k <= MAX_PAYLOAD_DEF + 1; k++) send_byte(8'(k * 8'h11));
    endtask

    task automatic test_random_traffic();
        run_random_phase(140);
        apply_config(8'hFF, 8'hFF);
        run_random_phase(140);
        throttle_en = 1'b0;
        apply_config(8'hFF, 8'h00);
        run_random_phase(140);
        throttle_en = 1'b1;
        apply_config(8'h00, 8'h00);
        run_random_phase(140);
        apply_config(8'($urandom_range(255)), 8'($urandom_range(255)));
        run_random_phase(150);
        apply_config(8'hA5, 8'h5A);
        run_random_phase(150);
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CFG_START_MARKER;
        i_cfg_data    <= '0;
        rx_if.valid   <= 1'b0;
        rx_if.rx_byte <= '0;
        cur_marker    = START_MARKER_RST;
        cur_power_id  = POWER_ID_RST;
        parse_ph      = PH_HUNT1;
        cur_id        = '0;
        cur_len       = '0;
        data_count    = '0;
        data_acc      = '0;
        switches_now  = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_broken_pair_and_triple_start();
        test_power_frames();
        test_oversize_frame();
        test_random_traffic();

        settle();
        repeat (2 * SETTLE_WAIT) @(posedge i_clk);
        if (pending_frames.size() != 0) begin
            err_count++;
            $display("%0t: %0d frame reports never arrived", $time, pending_frames.size());
        end
        if (err_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
